@@ sv/c_octal_escape_quoter_unit_defines.svh @@
// Assertion macros shared by the octal escape quoter RTL.
// Include this file in modules that clock on clock and reset on reset.
`ifndef C_OCTAL_ESCAPE_QUOTER_UNIT_DEFINES_SVH
`define C_OCTAL_ESCAPE_QUOTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COEQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/coeq_pkg.sv @@
// Package for the octal escape quoter: payload types, job descriptor and constants.
// No dependencies.
`timescale 1ns / 1ps

package coeq_pkg;

   localparam logic [7:0] NOTHING_PENDING = 8'd32;
   localparam logic [7:0] PRINT_LO        = 8'd32;
   localparam logic [7:0] PRINT_HI        = 8'd126;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_SHORT = 2'd1;
   localparam logic [1:0] ESC_LONG  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       flush;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] esc_kind;
      logic [7:0] esc_byte;
      logic       has_pass;
      logic [7:0] pass_byte;
   } job_type;

   typedef struct packed {
      logic full;
      logic avail;
   } queue_status_type;

endpackage

@@ sv/coeq_front.sv @@
// Front end of the octal escape quoter: accepts beats, tracks the pending byte
// and turns beats that complete a run into output jobs. Depends on coeq_pkg.
`timescale 1ns / 1ps

module coeq_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  coeq_pkg::req_payload_type req_data,
   input  coeq_pkg::queue_status_type q_status,
   output logic                      job_push,
   output coeq_pkg::job_type         job
);
   import coeq_pkg::*;

   logic [7:0] pending_ff;
   logic [7:0] pending_in;
   logic       accept;
   logic       have;
   logic       printable;
   logic       digit;
   logic       make_job;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   assign have      = pending_ff != NOTHING_PENDING;
   assign printable = (req_data.in_byte >= PRINT_LO) && (req_data.in_byte <= PRINT_HI);
   assign digit     = (req_data.in_byte >= CHAR_ZERO) && (req_data.in_byte <= CHAR_NINE);

   always_comb begin
      pending_in     = pending_ff;
      make_job       = 1'b0;
      job.esc_kind   = ESC_NONE;
      job.esc_byte   = pending_ff;
      job.has_pass   = 1'b0;
      job.pass_byte  = req_data.in_byte;
      if (req_data.flush) begin
         if (have) begin
            make_job     = 1'b1;
            job.esc_kind = ESC_SHORT;
            pending_in   = NOTHING_PENDING;
         end
      end else if (!have) begin
         if (printable) begin
            make_job     = 1'b1;
            job.has_pass = 1'b1;
         end else begin
            pending_in = req_data.in_byte;
         end
      end else if (!printable) begin
         make_job     = 1'b1;
         job.esc_kind = ESC_SHORT;
         pending_in   = req_data.in_byte;
      end else if (digit) begin
         make_job     = 1'b1;
         job.esc_kind = ESC_LONG;
         job.has_pass = 1'b1;
         pending_in   = NOTHING_PENDING;
      end else begin
         make_job     = 1'b1;
         job.esc_kind = ESC_SHORT;
         job.has_pass = 1'b1;
         pending_in   = NOTHING_PENDING;
      end
   end

   assign job_push = accept && make_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= NOTHING_PENDING;
      end else if (accept) begin
         pending_ff <= pending_in;
      end
   end

endmodule

@@ sv/coeq_queue.sv @@
// Short job queue between the front end and the output sequencer.
// Depends on coeq_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "c_octal_escape_quoter_unit_defines.svh"

module coeq_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  coeq_pkg::job_type          push_job,
   input  logic                       pop,
   output coeq_pkg::job_type          head_job,
   output coeq_pkg::queue_status_type status
);
   import coeq_pkg::*;

   job_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_in;

   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.avail = count_ff != '0;
   assign head_job     = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                      : wr_ptr_ff + QUEUE_PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                      : rd_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `COEQ_ASSERT_IMPLIES(a_queue_count_range, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
   `COEQ_ASSERT_IMPLIES(a_queue_no_overflow, push && !pop, !status.full, "push into a full queue")
   `COEQ_ASSERT_IMPLIES(a_queue_no_underflow, pop, status.avail, "pop from an empty queue")

endmodule

@@ sv/coeq_back.sv @@
// Output sequencer of the octal escape quoter: expands each job into result beats,
// one per cycle unless stalled, via an output register. Needs coeq_pkg and macros.
`timescale 1ns / 1ps
`include "c_octal_escape_quoter_unit_defines.svh"

module coeq_back (
   input  logic                       clock,
   input  logic                       reset,
   input  coeq_pkg::job_type          head_job,
   input  coeq_pkg::queue_status_type q_status,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output coeq_pkg::rsp_payload_type  rsp_data
);
   import coeq_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic [1:0] num_digits;
   logic [2:0] run_len;
   logic [2:0] digit_pos;
   logic [2:0] digit_val;
   logic [7:0] cur_byte;
   logic       is_last;
   logic       load;

   always_comb begin
      case (head_job.esc_kind)
         ESC_SHORT: begin
            if (head_job.esc_byte[7:6] != 2'd0) begin
               num_digits = 2'd3;
            end else if (head_job.esc_byte[5:3] != 3'd0) begin
               num_digits = 2'd2;
            end else begin
               num_digits = 2'd1;
            end
         end
         ESC_LONG: begin
            num_digits = 2'd3;
         end
         default: begin
            num_digits = 2'd0;
         end
      endcase
   end

   assign run_len = (head_job.esc_kind == ESC_NONE) ? 3'd1
                    : 3'd1 + {1'b0, num_digits} + {2'b0, head_job.has_pass};

   assign digit_pos = 3'd3 - {1'b0, num_digits} + idx_ff - 3'd1;

   always_comb begin
      case (digit_pos)
         3'd0:    digit_val = {1'b0, head_job.esc_byte[7:6]};
         3'd1:    digit_val = head_job.esc_byte[5:3];
         default: digit_val = head_job.esc_byte[2:0];
      endcase
   end

   always_comb begin
      if (head_job.esc_kind == ESC_NONE) begin
         cur_byte = head_job.pass_byte;
      end else if (idx_ff == 3'd0) begin
         cur_byte = CHAR_BACKSLASH;
      end else if (idx_ff <= {1'b0, num_digits}) begin
         cur_byte = CHAR_ZERO + {5'b0, digit_val};
      end else begin
         cur_byte = head_job.pass_byte;
      end
   end

   assign is_last = idx_ff == (run_len - 3'd1);
   assign load    = q_status.avail && (!out_valid_ff || rsp_pop);
   assign job_pop = load && is_last;
   assign idx_in  = is_last ? 3'd0 : idx_ff + 3'd1;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= cur_byte;
         out_last_ff <= is_last;
      end
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_data.out_byte    = out_byte_ff;
   assign rsp_data.last_of_run = out_last_ff;

   `COEQ_ASSERT_IMPLIES(a_back_mid_job_has_head, idx_ff != 3'd0, q_status.avail, "sequencer mid-job without a queued job")
   `COEQ_ASSERT_IMPLIES(a_back_idx_in_run, q_status.avail, idx_ff < run_len, "beat index beyond job length")
   `COEQ_ASSERT_NEXT(a_back_idx_step, load && !is_last, idx_ff == $past(idx_ff) + 3'd1, "beat index did not advance")

endmodule

@@ sv/c_octal_escape_quoter_unit.sv @@
// C-style octal escape quoter, top level: front end, job queue and output sequencer.
// Depends on coeq_pkg, coeq_front, coeq_queue and coeq_back.
`timescale 1ns / 1ps

// Each input beat is a raw byte or a flush marker; the result side delivers the escaped
// text one byte per beat, with last_of_run set on the final byte caused by an input.
// An input is taken while the two-entry job queue has room; an input that yields n
// result bytes (0 to 5) holds the output sequencer for all n of them; the sustained
// rate is one result byte per cycle unless stalled, set by the single output register.
module c_octal_escape_quoter_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  coeq_pkg::req_payload_type req_data,
   output logic                      empty,
   input  logic                      pop,
   output coeq_pkg::rsp_payload_type rsp_data
);
   import coeq_pkg::*;

   job_type          front_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             job_push;
   logic             job_pop;

   coeq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_full (full),
      .req_data (req_data),
      .q_status (q_status),
      .job_push (job_push),
      .job      (front_job)
   );

   coeq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   coeq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .job_pop   (job_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/c_octal_escape_quoter_unit_checker.sv @@
// Scoreboard for the octal escape quoter: predicts the escaped text of every input beat
// and compares each result beat against it. Depends on coeq_pkg.
`timescale 1ns / 1ps

module c_octal_escape_quoter_unit_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      full,
   input  coeq_pkg::req_payload_type req_data,
   input  logic                      empty,
   input  logic                      pop,
   input  coeq_pkg::rsp_payload_type rsp_data,
   output int                        mismatch_count,
   output int                        results_owed
);
   import coeq_pkg::*;

   rsp_payload_type quoted_text[$];
   logic [7:0]      run_bytes[$];
   logic [7:0]      held_byte;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic int short_digits(input logic [7:0] value);
      if (value < 8'd8) return 1;
      if (value < 8'd64) return 2;
      return 3;
   endfunction

   task automatic add_escape(input logic [7:0] value, input int digits);
      logic [7:0] octal;
      run_bytes.push_back(CHAR_BACKSLASH);
      for (int d = digits - 1; d >= 0; d--) begin
         octal = (value >> (3 * d)) & 8'd7;
         run_bytes.push_back(CHAR_ZERO + octal);
      end
   endtask

   task automatic quote_beat(input req_payload_type beat);
      logic            printable;
      logic            digit;
      rsp_payload_type beat_out;
      printable = beat.in_byte >= PRINT_LO && beat.in_byte <= PRINT_HI;
      digit     = beat.in_byte >= CHAR_ZERO && beat.in_byte <= CHAR_NINE;
      run_bytes.delete();
      if (beat.flush) begin
         if (held_byte != NOTHING_PENDING) begin
            add_escape(held_byte, short_digits(held_byte));
            held_byte = NOTHING_PENDING;
         end
      end else if (held_byte == NOTHING_PENDING) begin
         if (printable) run_bytes.push_back(beat.in_byte);
         else held_byte = beat.in_byte;
      end else if (!printable) begin
         add_escape(held_byte, short_digits(held_byte));
         held_byte = beat.in_byte;
      end else begin
         // A digit right after an escape forces the full three-digit form.
         add_escape(held_byte, digit ? 3 : short_digits(held_byte));
         run_bytes.push_back(beat.in_byte);
         held_byte = NOTHING_PENDING;
      end
      foreach (run_bytes[i]) begin
         beat_out.out_byte    = run_bytes[i];
         beat_out.last_of_run = (i == run_bytes.size() - 1);
         quoted_text.push_back(beat_out);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type owed;
      if (reset) begin
         held_byte = NOTHING_PENDING;
         quoted_text.delete();
      end else begin
         if (push && !full) quote_beat(req_data);
         if (pop && !empty) begin
            if (quoted_text.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected result beat, out_byte %02h last_of_run %0b",
                  rsp_data.out_byte, rsp_data.last_of_run));
            end else begin
               owed = quoted_text.pop_front();
               if (rsp_data.out_byte != owed.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_data.out_byte, owed.out_byte));
               if (rsp_data.last_of_run != owed.last_of_run)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b on out_byte %02h",
                                            rsp_data.last_of_run, owed.last_of_run,
                                            owed.out_byte));
            end
         end
      end
      results_owed <= quoted_text.size();
   end

endmodule

@@ dv/tb_c_octal_escape_quoter_unit.sv @@
// Testbench top for the octal escape quoter: drives directed and random byte streams,
// stalls the result side at random, and gives the verdict. Depends on coeq_pkg, the
// quoter RTL and c_octal_escape_quoter_unit_checker.
`timescale 1ns / 1ps

module tb_c_octal_escape_quoter_unit;
   import coeq_pkg::*;

   logic            clock;
   logic            reset;
   logic            push;
   logic            full;
   req_payload_type req_data;
   logic            empty;
   logic            pop;
   rsp_payload_type rsp_data;
   int              mismatch_count;
   int              results_owed;
   logic            steady;
   logic            hold_off_request;

   c_octal_escape_quoter_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   c_octal_escape_quoter_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("tb_c_octal_escape_quoter_unit: FAIL");
      $finish;
   end

   task automatic send_beat(input logic [7:0] value, input logic flush);
      req_payload_type beat;
      beat.in_byte = value;
      beat.flush   = flush;
      while (!steady && $urandom_range(99) < 27) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full);
   endtask

   task automatic send_random_beat();
      int         pick;
      logic [7:0] value;
      pick = $urandom_range(99);
      if (pick < 6) begin
         send_beat(8'($urandom), 1'b1);
      end else begin
         if (pick < 42) begin
            if ($urandom_range(1) != 0) value = 8'($urandom_range(31, 0));
            else value = 8'($urandom_range(255, 127));
         end else if (pick < 62) begin
            value = 8'($urandom_range(CHAR_NINE, CHAR_ZERO));
         end else begin
            value = 8'($urandom_range(PRINT_HI, PRINT_LO));
         end
         send_beat(value, 1'b0);
      end
   endtask

   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_data         = '0;
      steady           = 1'b0;
      hold_off_request = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_beat(8'h00, 1'b1);
      send_beat(PRINT_LO, 1'b0);
      send_beat(PRINT_HI, 1'b0);
      send_beat(CHAR_BACKSLASH, 1'b0);
      send_beat(8'h22, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h35, 1'b0);
      send_beat(8'h07, 1'b0);
      send_beat(8'h78, 1'b0);
      send_beat(8'h08, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h3F, 1'b0);
      send_beat(8'h40, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CHAR_NINE, 1'b0);
      send_beat(8'h1F, 1'b0);
      send_beat(CHAR_ZERO, 1'b0);
      send_beat(8'h1F, 1'b0);
      send_beat(8'h2F, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h3A, 1'b0);
      send_beat(8'hC8, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);

      for (int i = 0; i < 135; i++) begin
         steady = (i >= 60 && i < 110);
         if (i == 80) hold_off_request = 1'b1;
         send_random_beat();
      end
      push <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb_c_octal_escape_quoter_unit: PASS");
      end else begin
         $display("tb_c_octal_escape_quoter_unit: FAIL");
      end
      $finish;
   end

   initial begin
      wait (!reset);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            pop <= 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            pop <= steady || $urandom_range(99) >= 27;
            @(posedge clock);
         end
      end
   end

endmodule
